// ===== src/sha256_pkg.sv =====
// shared types, round constants and hash functions for the sha-256 block
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic start;
    logic chain_init;
  } core_ctrl_t;

  localparam int unsigned ROUNDS = 64;

  localparam word_t INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [0:ROUNDS-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== src/sha256_core.sv =====
// compression engine: one round per cycle over a sliding schedule window
module sha256_core (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256_pkg::core_ctrl_t  ctrl,
  input  sha256_pkg::block_t      block,
  output logic                    done,
  output sha256_pkg::chain_t      chain
);
  import sha256_pkg::*;

  logic       busy;
  logic [5:0] round;
  block_t     win;
  chain_t     wv;
  chain_t     wv_next;
  word_t      w_new;
  word_t      t1;
  word_t      t2;

  // win[0] is the schedule word of the current round; w_new is the word 16 rounds ahead
  always_comb begin
    w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    t1 = wv[7] + big_sigma1(wv[4]) + choose(wv[4], wv[5], wv[6]) + ROUND_K[round] + win[0];
    t2 = big_sigma0(wv[0]) + majority(wv[0], wv[1], wv[2]);
    wv_next[0] = t1 + t2;
    wv_next[1] = wv[0];
    wv_next[2] = wv[1];
    wv_next[3] = wv[2];
    wv_next[4] = wv[3] + t1;
    wv_next[5] = wv[4];
    wv_next[6] = wv[5];
    wv_next[7] = wv[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
      for (int j = 0; j < 8; j++) begin
        chain[j] <= INIT_HASH[j];
      end
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'(ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (done) begin
        for (int j = 0; j < 8; j++) begin
          chain[j] <= chain[j] + wv[j];
        end
      end
      if (ctrl.chain_init) begin
        for (int j = 0; j < 8; j++) begin
          chain[j] <= INIT_HASH[j];
        end
      end
    end
  end

  // datapath registers, loaded on start and stepped once per round
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      win <= block;
      wv  <= chain;
    end else if (busy) begin
      win <= {w_new, win[15:1]};
      wv  <= wv_next;
    end
  end

endmodule

// ===== src/sha256_hash.sv =====
// sha-256 top level: byte packing, padding sequencer and digest output
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid/in_stall  | data_byte, has_byte, end_of_message
//  output   | out_valid/out_stall| digest_word, word_index, last_word
//
// a byte that neither fills the block nor ends the message leaves input unstalled
// a byte that fills the block stalls input through its compression: load, 64 rounds in the
// shared round unit, chain update
// the final transfer adds padding (pad and length states), one or two compressions
// and the digest output, one word per output transfer
// synchronous reset restores the initial hash, empties the buffer and bit count
// output stalls simply hold the current digest word; input stays stalled until done
module sha256_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // which compression is running
  localparam logic [1:0] PH_DATA  = 2'd0;
  localparam logic [1:0] PH_WRAP  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic [63:0] bit_count;
  block_t      buffer;
  logic        pending_last;
  logic        core_start;
  logic [2:0]  out_idx;
  logic [5:0]  pos;
  logic [4:0]  lane_shift;
  logic        core_done;
  chain_t      chain;
  core_ctrl_t  ctrl;

  // byte position in the block and its big-endian lane inside the word
  assign pos        = bit_count[8:3];
  assign lane_shift = {~pos[1:0], 3'b000};

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  // chain goes back to the initial hash on the transfer of the last digest word
  assign ctrl.start      = core_start;
  assign ctrl.chain_init = (state == S_OUT) && !out_stall && (out_idx == 3'd7);

  sha256_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .block (buffer),
    .done  (core_done),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_DATA;
      bit_count    <= '0;
      buffer       <= '0;
      pending_last <= 1'b0;
      core_start   <= 1'b0;
      out_idx      <= '0;
    end else begin
      core_start <= 1'b0;
      // the core captures the buffer while start is high, so it can be emptied now
      if (core_start) begin
        buffer <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pending_last <= end_of_message;
            if (has_byte) begin
              buffer[pos[5:2]] <= buffer[pos[5:2]] | ({24'd0, data_byte} << lane_shift);
              bit_count        <= bit_count + 64'd8;
            end
            if (has_byte && (pos == 6'd63)) begin
              // block full: compress before anything else
              core_start <= 1'b1;
              phase      <= PH_DATA;
              state      <= S_RUN;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_RUN: begin
          if (core_done) begin
            unique case (phase)
              PH_DATA:  state <= pending_last ? S_PAD : S_IDLE;
              PH_WRAP:  state <= S_LEN;
              PH_FINAL: begin
                state   <= S_OUT;
                out_idx <= '0;
              end
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_PAD: begin
          buffer[pos[5:2]] <= buffer[pos[5:2]] | ({24'd0, PAD_BYTE} << lane_shift);
          if (pos >= 6'd56) begin
            // no room for the length: an extra block carries it
            core_start <= 1'b1;
            phase      <= PH_WRAP;
            state      <= S_RUN;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          buffer[14] <= bit_count[63:32];
          buffer[15] <= bit_count[31:0];
          core_start <= 1'b1;
          phase      <= PH_FINAL;
          state      <= S_RUN;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state        <= S_IDLE;
              bit_count    <= '0;
              pending_last <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
